// File: rtl/jse_pkg.sv
// jse_pkg: shared types, constants and helpers for the json string escaper
// with utf-8 check; used by jse_decode, jse_emit and the top level
// depends on nothing
`default_nettype none

package jse_pkg;

  // written-byte counter width
  localparam int COUNT_WIDTH = 16;
  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // most words one input byte can cause, and the width of a word count
  localparam int MAX_RES = 9;
  localparam int RES_W = 4;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_U   = 8'h75;

  // control codes with short escapes
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_HT = 8'h09;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_CR = 8'h0D;

  // utf-8 lead and follow limits
  localparam logic [7:0] LEAD_FLOOR   = 8'hC0;
  localparam logic [7:0] LEAD_MIN     = 8'hC2;
  localparam logic [7:0] LEAD_3B      = 8'hE0;
  localparam logic [7:0] LEAD_4B      = 8'hF0;
  localparam logic [7:0] LEAD_BAD     = 8'hF4;
  localparam logic [7:0] FOLLOW_C2_E0 = 8'hA0;
  localparam logic [7:0] FOLLOW_F0    = 8'h90;

  // replacement character U+FFFD
  localparam logic [7:0] REPL_0 = 8'hEF;
  localparam logic [7:0] REPL_1 = 8'hBF;
  localparam logic [7:0] REPL_2 = 8'hBD;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_PEND,
    MODE_SKIP
  } scan_mode_t;

  // control state of the scanner (the held sequence bytes live apart)
  typedef struct packed {
    scan_mode_t             mode;
    logic [1:0]             held;
    logic [1:0]             needed;
    logic [COUNT_WIDTH-1:0] written;
    logic [15:0]            budget;
    logic                   open;
  } scan_state_t;

  // all words caused by one input byte
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [RES_W-1:0]        count;
    logic                    close;
    logic [15:0]             wcount;
  } burst_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] d;
    if (v < 4'd10) begin
      d = CH_ZERO + {4'd0, v};
    end else begin
      d = 8'h61 + {4'd0, v} - 8'd10;
    end
    return d;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                     input logic [2:0] k);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + (COUNT_WIDTH+1)'(k);
    if (s > {1'b0, COUNT_MAX}) begin
      return COUNT_MAX;
    end
    return s[COUNT_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/jse_decode.sv
// jse_decode: combinational scan of one input byte against the scanner state;
// gives the next state and the burst of output words for that byte
// depends on jse_pkg
`default_nettype none

module jse_decode (
  input  jse_pkg::scan_state_t  cur_i,
  input  logic [2:0][7:0]       store_i,
  input  logic [7:0]            in_byte,
  input  logic [15:0]           in_text_budget,
  output jse_pkg::scan_state_t  nxt_o,
  output logic [2:0][7:0]       store_o,
  output jse_pkg::burst_t       burst_o
);
  import jse_pkg::*;

  scan_state_t            st;
  logic                   is_cont;
  logic                   bad;
  logic                   fresh;
  logic                   bopen;
  logic                   close;
  logic [3:0][7:0]        pre;
  logic [2:0]             pre_n;
  logic [7:0][7:0]        fr;
  logic [2:0]             fr_n;
  logic [COUNT_WIDTH-1:0] bw_mid;
  logic [3:0]             pos;

  always_comb begin
    // a new text samples its budget and starts from a clean count
    st = cur_i;
    if (!cur_i.open) begin
      st.budget  = in_text_budget;
      st.written = '0;
      st.mode    = MODE_PASS;
      st.open    = 1'b1;
    end

    is_cont = (in_byte[7:6] == 2'b10);
    nxt_o   = st;
    store_o = store_i;
    fresh   = 1'b1;
    bad     = 1'b0;
    pre     = '0;
    pre_n   = 3'd0;
    fr      = '0;
    fr_n    = 3'd0;
    close   = 1'b0;

    unique case (st.mode)
      MODE_PEND: begin
        bad = !is_cont;
        if (st.held == 2'd1) begin
          if ((store_i[0] == LEAD_MIN || store_i[0] == LEAD_3B) && in_byte < FOLLOW_C2_E0) begin
            bad = 1'b1;
          end
          if (store_i[0] == LEAD_4B && in_byte < FOLLOW_F0) begin
            bad = 1'b1;
          end
        end
        if (!bad) begin
          fresh = 1'b0;
          if (st.held < st.needed) begin
            store_o[st.held] = in_byte;
            nxt_o.held       = st.held + 2'd1;
          end else begin
            // sequence complete: copy it out whole
            pre[0]       = store_i[0];
            pre[1]       = store_i[1];
            pre[2]       = store_i[2];
            pre[st.held] = in_byte;
            pre_n        = 3'(st.held) + 3'd1;
            nxt_o.held   = 2'd0;
            nxt_o.needed = 2'd0;
            nxt_o.mode   = MODE_PASS;
          end
        end else begin
          pre[0]       = REPL_0;
          pre[1]       = REPL_1;
          pre[2]       = REPL_2;
          pre_n        = 3'd3;
          nxt_o.held   = 2'd0;
          nxt_o.needed = 2'd0;
          if (is_cont) begin
            nxt_o.mode = MODE_SKIP;
            fresh      = 1'b0;
          end else begin
            nxt_o.mode = MODE_PASS;
          end
        end
      end
      MODE_SKIP: begin
        if (is_cont) begin
          fresh = 1'b0;
        end else begin
          nxt_o.mode = MODE_PASS;
        end
      end
      default: begin
      end
    endcase

    bw_mid = sat_add(st.written, pre_n);
    bopen  = (bw_mid < COUNT_MAX) && (CMP_W'(bw_mid) < CMP_W'(st.budget));

    if (fresh) begin
      if (in_byte == CH_NUL) begin
        close        = 1'b1;
        nxt_o.open   = 1'b0;
        nxt_o.mode   = MODE_PASS;
        nxt_o.held   = 2'd0;
        nxt_o.needed = 2'd0;
      end else if (bopen) begin
        if (in_byte < CH_SPACE) begin
          fr[0] = CH_BSLASH;
          fr_n  = 3'd2;
          unique case (in_byte)
            CTL_BS:  fr[1] = CH_LC_B;
            CTL_HT:  fr[1] = CH_LC_T;
            CTL_LF:  fr[1] = CH_LC_N;
            CTL_FF:  fr[1] = CH_LC_F;
            CTL_CR:  fr[1] = CH_LC_R;
            default: begin
              fr[1] = CH_LC_U;
              fr[2] = CH_ZERO;
              fr[3] = CH_ZERO;
              fr[4] = hex_digit(in_byte[7:4]);
              fr[5] = hex_digit(in_byte[3:0]);
              fr_n  = 3'd6;
            end
          endcase
        end else if (in_byte == CH_QUOTE || in_byte == CH_BSLASH) begin
          fr[0] = CH_BSLASH;
          fr[1] = in_byte;
          fr_n  = 3'd2;
        end else if (in_byte <= CH_TILDE) begin
          fr[0] = in_byte;
          fr_n  = 3'd1;
        end else if (in_byte < LEAD_FLOOR) begin
          // stray delete or continuation byte
          fr[0] = CH_COMMA;
          fr_n  = 3'd1;
        end else if (in_byte < LEAD_MIN || in_byte >= LEAD_BAD) begin
          fr[0]      = REPL_0;
          fr[1]      = REPL_1;
          fr[2]      = REPL_2;
          fr_n       = 3'd3;
          nxt_o.mode = MODE_SKIP;
        end else begin
          store_o[0]   = in_byte;
          nxt_o.held   = 2'd1;
          nxt_o.needed = (in_byte < LEAD_3B) ? 2'd1 : ((in_byte < LEAD_4B) ? 2'd2 : 2'd3);
          nxt_o.mode   = MODE_PEND;
        end
      end
    end

    nxt_o.written  = close ? '0 : sat_add(bw_mid, fr_n);
    burst_o.close  = close;
    burst_o.wcount = 16'(bw_mid);
    burst_o.count  = RES_W'(pre_n) + RES_W'(fr_n) + RES_W'(close);

    // repl or sequence bytes first, then the fresh bytes, closing word last
    for (int i = 0; i < MAX_RES; i++) begin
      pos = 4'(i) - {1'b0, pre_n};
      if (4'(i) < {1'b0, pre_n}) begin
        burst_o.bytes[i] = pre[2'(i)];
      end else if (pos < {1'b0, fr_n}) begin
        burst_o.bytes[i] = fr[pos[2:0]];
      end else begin
        burst_o.bytes[i] = '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/jse_emit.sv
// jse_emit: burst buffer and output register; sends the words of one input
// byte one per cycle while out_ready allows, and takes the next burst as the last word leaves
// depends on jse_pkg
`default_nettype none

module jse_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load_i,
  input  jse_pkg::burst_t burst_i,
  output logic            room_o,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_end_of_text,
  output logic [15:0]     out_written_count,
  output logic            out_last_of_run
);
  import jse_pkg::*;

  burst_t           buf_r;
  logic [RES_W-1:0] buf_n_r;
  logic [RES_W-1:0] buf_idx_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_bv_r;
  logic             out_eot_r;
  logic [15:0]      out_cnt_r;
  logic             out_last_r;
  logic             buf_has;
  logic             move;
  logic             is_last;
  logic             is_close;

  assign buf_has  = buf_idx_r < buf_n_r;
  assign move     = buf_has && (!out_valid_r || out_ready);
  assign is_last  = (buf_idx_r + RES_W'(1)) == buf_n_r;
  assign is_close = is_last && buf_r.close;
  assign room_o   = !buf_has || (is_last && move);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_n_r   <= '0;
      buf_idx_r <= '0;
    end else if (load_i) begin
      buf_n_r   <= burst_i.count;
      buf_idx_r <= '0;
    end else if (move) begin
      buf_idx_r <= buf_idx_r + RES_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      buf_r <= burst_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte_r <= buf_r.bytes[buf_idx_r];
      out_bv_r   <= !is_close;
      out_eot_r  <= is_close;
      out_cnt_r  <= is_close ? buf_r.wcount : 16'd0;
      out_last_r <= is_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_byte_valid    = out_bv_r;
  assign out_end_of_text   = out_eot_r;
  assign out_written_count = out_cnt_r;
  assign out_last_of_run   = out_last_r;

endmodule

`default_nettype wire

// File: rtl/json_string_escaper_utf8_check.sv
// json_string_escaper_utf8_check: top level; scanner state registers,
// decode of each input byte and the output burst stage
// depends on jse_pkg, jse_decode and jse_emit
`default_nettype none

// Streaming JSON string escaper with UTF-8 checking. One text byte per input
// word, a zero byte closes the text and yields a closing word carrying the
// count of bytes written; the budget is sampled on the first byte of a text.
// A byte that yields no output or one output word is taken every cycle while
// out_ready keeps the output moving; a byte that yields more (up to nine: a
// replacement plus a \u00xx escape) holds the input until the single output
// register takes its last word, one per cycle unless stalled. Bursts pass
// the burst buffer, then the output register. No sweep: ready after reset.
module json_string_escaper_utf8_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic [15:0] in_text_budget,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_end_of_text,
  output logic [15:0] out_written_count,
  output logic        out_last_of_run
);
  import jse_pkg::*;

  scan_state_t     state_r;
  scan_state_t     state_nxt;
  logic [2:0][7:0] store_r;
  logic [2:0][7:0] store_nxt;
  burst_t          burst;
  logic            room;
  logic            in_accept;

  assign in_ready  = room;
  assign in_accept = in_valid && room;

  jse_decode u_decode (
    .cur_i          (state_r),
    .store_i        (store_r),
    .in_byte        (in_byte),
    .in_text_budget (in_text_budget),
    .nxt_o          (state_nxt),
    .store_o        (store_nxt),
    .burst_o        (burst)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode    <= MODE_PASS;
      state_r.held    <= '0;
      state_r.needed  <= '0;
      state_r.written <= '0;
      state_r.budget  <= '0;
      state_r.open    <= 1'b0;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // held sequence bytes are only read after being written
  always_ff @(posedge clk) begin
    if (in_accept) begin
      store_r <= store_nxt;
    end
  end

  jse_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .load_i            (in_accept),
    .burst_i           (burst),
    .room_o            (room),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_end_of_text   (out_end_of_text),
    .out_written_count (out_written_count),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

`default_nettype wire
